// ===== rtl/pqe_pkg.sv =====
// ----------------------------------------------------------------------------
// pqe_pkg: shared types and constants for the PQ nearest-centroid encoder
// Sizes, config indices, command/status and stream payload structs.
// ----------------------------------------------------------------------------
package pqe_pkg;
  localparam int MAX_SUBSPACES = 8;
  localparam int MAX_SUB_WIDTH = 16;
  localparam int MAX_CODE_BITS = 8;

  localparam int SUB_W  = 3;
  localparam int CEN_W  = 8;
  localparam int DIM_W  = 4;
  localparam int ADDR_W = SUB_W + CEN_W + DIM_W;
  localparam int DIST_W = 38;

  localparam logic [1:0] CFG_SUBSPACE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SUBSPACE_WIDTH = 2'd1;
  localparam logic [1:0] CFG_CODE_BITS      = 2'd2;

  localparam logic KIND_BOOK    = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  typedef struct packed {
    logic                  clear;    // start a centroid scan
    logic                  issue;    // issue a codebook read
    logic [CEN_W-1:0]      cen;
    logic [DIM_W-1:0]      dim;
    logic                  dim_last; // issued word is the last of its centroid
  } pqe_cmd_t;

  typedef struct packed {
    logic             busy;     // reads or accumulation still in flight
    logic [CEN_W-1:0] best;
  } pqe_stat_t;

  typedef struct packed {
    logic              kind;
    logic [SUB_W-1:0]  book_subspace;
    logic [CEN_W-1:0]  book_centroid;
    logic [DIM_W-1:0]  book_dim;
    logic signed [15:0] element;
  } pqe_in_t;

  typedef struct packed {
    logic [CEN_W-1:0] code;
    logic [SUB_W-1:0] code_subspace;
    logic             last;
  } pqe_out_t;
endpackage

// ===== rtl/pqe_stream_if.sv =====
// ----------------------------------------------------------------------------
// pqe_stream_if: valid/ready channel
// Carries one payload of the given type per transfer.
// ----------------------------------------------------------------------------
interface pqe_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pqe_datapath.sv =====
// ----------------------------------------------------------------------------
// pqe_datapath: codebook memory, subvector buffer, distance accumulator
// One codebook word read per cycle; squared difference and running min.
// ----------------------------------------------------------------------------
module pqe_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              book_we,
  input  logic [pqe_pkg::ADDR_W-1:0]        book_addr,
  input  logic signed [15:0]                book_data,
  input  logic                              vec_we,
  input  logic [pqe_pkg::DIM_W-1:0]         vec_idx,
  input  logic [pqe_pkg::SUB_W-1:0]         scan_sub,
  input  pqe_pkg::pqe_cmd_t                 cmd,
  output pqe_pkg::pqe_stat_t                stat
);
  import pqe_pkg::*;

  logic signed [15:0] book_mem [0:(1<<ADDR_W)-1];
  logic signed [15:0] vec_r [0:MAX_SUB_WIDTH-1];

  // stage 1: memory read + vector tap
  logic signed [15:0] rd_r, vx_r;
  logic               v1_r, last1_r;
  logic [CEN_W-1:0]   cen1_r;
  // stage 2: squared difference
  logic [33:0]        sq_r;
  logic               v2_r, last2_r;
  logic [CEN_W-1:0]   cen2_r;
  // accumulation
  logic [DIST_W-1:0]  acc_r, best_dist_r;
  logic [CEN_W-1:0]   best_r;
  logic               have_r;

  always_ff @(posedge clk) begin
    if (book_we) book_mem[book_addr] <= book_data;
    if (vec_we) vec_r[vec_idx] <= book_data;
    rd_r <= book_mem[{scan_sub, cmd.cen, cmd.dim}];
    vx_r <= vec_r[cmd.dim];
    cen1_r <= cmd.cen;
    last1_r <= cmd.dim_last;
  end

  logic signed [16:0] diff;
  logic [16:0]        mag;
  assign diff = 17'(vx_r) - 17'(rd_r);
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk) begin
    sq_r    <= 34'(mag) * 34'(mag);
    cen2_r  <= cen1_r;
    last2_r <= last1_r;
  end

  logic [DIST_W-1:0] sum;
  assign sum = acc_r + DIST_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; have_r <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.clear) begin
        have_r <= 1'b0;
        acc_r  <= '0;
      end else if (v2_r) begin
        if (last2_r) begin
          acc_r <= '0;
          if (!have_r || sum < best_dist_r) begin
            best_dist_r <= sum;
            best_r      <= cen2_r;
          end
          have_r <= 1'b1;
        end else begin
          acc_r <= sum;
        end
      end
    end
  end

  assign stat.busy = v1_r | v2_r;
  assign stat.best = best_r;
endmodule

// ===== rtl/pqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqe_ctrl: scan sequencer
// Walks centroid by dimension over one subspace, waits for drain and a free
// output slot.
// ----------------------------------------------------------------------------
module pqe_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pqe_pkg::DIM_W:0]    width,
  input  logic [3:0]                 bits,
  input  pqe_pkg::pqe_stat_t         stat,
  input  logic                       out_free,
  output pqe_pkg::pqe_cmd_t          cmd,
  output logic                       done,
  output logic                       idle
);
  import pqe_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CEN_W:0]   cen_r, cen_nxt;
  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic             dim_end, cen_end;
  logic [CEN_W:0]   ncent;

  assign ncent   = (CEN_W+1)'(1) << bits;
  assign dim_end = ((DIM_W+1)'(dim_r) + 1'b1) == width;
  assign cen_end = (cen_r + 1'b1) == ncent;

  always_comb begin
    state_nxt = state_r;
    cen_nxt   = cen_r;
    dim_nxt   = dim_r;
    cmd.clear = 1'b0;
    cmd.issue = 1'b0;
    cmd.cen   = cen_r[CEN_W-1:0];
    cmd.dim   = dim_r;
    cmd.dim_last = dim_end;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.clear = 1'b1;
          cen_nxt   = '0;
          dim_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (dim_end) begin
          dim_nxt = '0;
          cen_nxt = cen_r + 1'b1;
          if (cen_end) state_nxt = ST_DRAIN;
        end else begin
          dim_nxt = dim_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy && out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cen_r   <= '0;
      dim_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cen_r   <= cen_nxt;
      dim_r   <= dim_nxt;
    end
  end

  assign idle = (state_r == ST_IDLE);
endmodule

// ===== rtl/pq_nearest_centroid_encoder.sv =====
// ----------------------------------------------------------------------------
// pq_nearest_centroid_encoder: product-quantization encoder
// Codebook load, subvector buffering and exhaustive nearest-centroid search.
// ----------------------------------------------------------------------------
// An element transfer that completes a subspace starts a scan that reads one
// codebook word per cycle from a single-port-read memory: input stalls while
// the start pulse is registered, every centroid is scanned, the pipeline
// drains and the code is handed off to the output register. Codebook writes
// and elements that do not complete a subspace start no scan. A finished code
// may wait in the output register while new items are taken; a later scan
// that finishes while it still waits holds in drain, and no input is taken
// until the slot frees. Ties go to the lowest centroid index; out-of-range
// register values are saturated.
module pq_nearest_centroid_encoder (
  input  logic       clk,
  input  logic       rst_n,
  pqe_stream_if.sink   in_ch,
  pqe_stream_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);
  import pqe_pkg::*;

  // configuration (raw values, saturated on use)
  logic [3:0] sub_count_r;
  logic [4:0] sub_width_r;
  logic [3:0] code_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_count_r <= 4'd8;
      sub_width_r <= 5'd16;
      code_bits_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SUBSPACE_COUNT: sub_count_r <= cfg_data[3:0];
        CFG_SUBSPACE_WIDTH: sub_width_r <= cfg_data;
        CFG_CODE_BITS:      code_bits_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [3:0] count_c, bits_c;
  logic [4:0] width_c;
  assign count_c = (sub_count_r == 0) ? 4'd1 :
                   (sub_count_r > 4'(MAX_SUBSPACES)) ? 4'(MAX_SUBSPACES) : sub_count_r;
  assign width_c = (sub_width_r == 0) ? 5'd1 :
                   (sub_width_r > 5'(MAX_SUB_WIDTH)) ? 5'(MAX_SUB_WIDTH) : sub_width_r;
  assign bits_c  = (code_bits_r == 0) ? 4'd1 :
                   (code_bits_r > 4'(MAX_CODE_BITS)) ? 4'(MAX_CODE_BITS) : code_bits_r;

  // element position and subspace tracking; position never needs >16
  logic [4:0]       pos_r;
  logic [SUB_W:0]   cur_sub_r;
  logic             out_valid_r;
  logic [SUB_W-1:0] scan_sub_r;
  logic             scan_last_r;
  pqe_out_t         out_r;

  logic idle, done, in_xfer, elem_xfer, completes;
  pqe_cmd_t  cmd;
  pqe_stat_t stat;

  assign in_ch.ready = idle;
  assign in_xfer   = in_ch.valid & in_ch.ready;
  assign elem_xfer = in_xfer & (in_ch.data.kind == KIND_ELEMENT);
  assign completes = elem_xfer & ((pos_r + 5'd1) >= width_c);

  logic [SUB_W:0] sub_sat;
  assign sub_sat = (cur_sub_r < (SUB_W+1)'(MAX_SUBSPACES)) ? cur_sub_r
                 : (SUB_W+1)'(MAX_SUBSPACES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cur_sub_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (elem_xfer) pos_r <= completes ? 5'd0 : pos_r + 5'd1;
      if (completes) begin
        scan_sub_r  <= sub_sat[SUB_W-1:0];
        scan_last_r <= ((cur_sub_r + 1'b1) >= (SUB_W+1)'(count_c));
        cur_sub_r   <= ((cur_sub_r + 1'b1) >= (SUB_W+1)'(count_c)) ? '0
                       : cur_sub_r + 1'b1;
      end
      if (done) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r.code          <= stat.best;
      out_r.code_subspace <= scan_sub_r;
      out_r.last          <= scan_last_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // output slot can take a new code: empty, or its code leaves this cycle
  logic out_free;
  assign out_free = ~out_valid_r | out_ch.ready;

  // start pulse is registered from the transfer, in the cycle after, so scan_sub_r is settled
  logic start_r;
  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= 1'b0;
    else start_r <= completes;
  end

  logic book_we, vec_we;
  assign book_we = in_xfer & (in_ch.data.kind == KIND_BOOK);
  assign vec_we  = elem_xfer & (pos_r < 5'(MAX_SUB_WIDTH));

  pqe_datapath u_dp (
    .clk, .rst_n,
    .book_we,
    .book_addr ({in_ch.data.book_subspace, in_ch.data.book_centroid, in_ch.data.book_dim}),
    .book_data (in_ch.data.element),
    .vec_we,
    .vec_idx   (pos_r[DIM_W-1:0]),
    .scan_sub  (scan_sub_r),
    .cmd,
    .stat
  );

  logic ctrl_idle;
  pqe_ctrl u_ctrl (
    .clk, .rst_n,
    .start    (start_r),
    .width    (width_c),
    .bits     (bits_c),
    .stat,
    .out_free (out_free),
    .cmd,
    .done,
    .idle     (ctrl_idle)
  );
  assign idle = ctrl_idle & ~start_r;

  // no new input while a scan is pending or running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || !ctrl_idle) |-> !in_ch.ready) else $error("input taken during scan");
  // a new code never overwrites one still waiting
  a_done_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_ch.ready)) else $error("result overwritten");
  // position stays inside the subspace width bound
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 5'(MAX_SUB_WIDTH)) else $error("element position overflow");
endmodule
